// ===== sv/sqlc_pkg.sv =====
// ----------------------------------------------------------------------------
// sqlc_pkg
// Shared types, byte codes and keyword tables for the read-only classifier.
// ----------------------------------------------------------------------------
package sqlc_pkg;

	localparam int unsigned NUM_WORDS = 5;
	localparam int unsigned WORD_CHARS = 8;

	typedef enum logic [2:0] {
		KW_NONE     = 3'd0,
		KW_SELECT   = 3'd1,
		KW_SHOW     = 3'd2,
		KW_DESCRIBE = 3'd3,
		KW_DESC     = 3'd4,
		KW_EXPLAIN  = 3'd5
	} kw_code_t;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// word k is listed in keyword-code order, code = k + 1
	localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_CHARS] = '{
		'{8'h53, 8'h45, 8'h4C, 8'h45, 8'h43, 8'h54, 8'h00, 8'h00},
		'{8'h53, 8'h48, 8'h4F, 8'h57, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h44, 8'h45, 8'h53, 8'h43, 8'h52, 8'h49, 8'h42, 8'h45},
		'{8'h44, 8'h45, 8'h53, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h45, 8'h58, 8'h50, 8'h4C, 8'h41, 8'h49, 8'h4E, 8'h00}
	};
	localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{4'd6, 4'd4, 4'd8, 4'd4, 4'd7};

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} sqlc_item_t;

	typedef struct packed {
		logic     valid;
		kw_code_t code;
	} sqlc_result_t;

	function automatic logic is_space(input logic [7:0] c);
		return c inside {[8'h09:8'h0D], 8'h20};
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A]}) ? (c - 8'h20) : c;
	endfunction

endpackage

// ===== sv/sqlc_scan.sv =====
// ----------------------------------------------------------------------------
// sqlc_scan
// Per-byte scanner: skips leading noise, folds and matches the first word.
// ----------------------------------------------------------------------------
module sqlc_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  sqlc_pkg::sqlc_item_t item,
	output sqlc_pkg::sqlc_result_t result
);
	import sqlc_pkg::*;

	typedef enum logic [2:0] {
		PH_NOISE,
		PH_SLASH,
		PH_DASH,
		PH_BLOCK,
		PH_BLOCK_STAR,
		PH_LINE,
		PH_WORD,
		PH_DONE
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [NUM_WORDS-1:0] mask_q, mask_n, letter_mask;
	logic [3:0]         cnt_q, cnt_n, cnt_inc;
	logic [7:0]         up;
	kw_code_t           code;

	always_comb begin
		up = to_upper(item.data);
		for (int k = 0; k < NUM_WORDS; k++) begin
			letter_mask[k] = mask_q[k] && (cnt_q < WORD_LEN[k]) &&
				(WORD_TEXT[k][cnt_q[2:0]] == up);
		end
		cnt_inc = (cnt_q == 4'hF) ? cnt_q : cnt_q + 4'd1;
	end

	always_comb begin
		phase_n = phase_q;
		mask_n  = mask_q;
		cnt_n   = cnt_q;
		if (item.present) begin
			case (phase_q)
				PH_NOISE: begin
					if (is_space(item.data)) begin
						phase_n = PH_NOISE;
					end else if (item.data == CH_SLASH) begin
						phase_n = PH_SLASH;
					end else if (item.data == CH_DASH) begin
						phase_n = PH_DASH;
					end else if (item.data == CH_HASH) begin
						phase_n = PH_LINE;
					end else if (is_letter(item.data)) begin
						phase_n = PH_WORD;
						mask_n  = letter_mask;
						cnt_n   = cnt_inc;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_SLASH: phase_n = (item.data == CH_STAR) ? PH_BLOCK : PH_DONE;
				PH_DASH:  phase_n = (item.data == CH_DASH) ? PH_LINE : PH_DONE;
				PH_BLOCK: begin
					if (item.data == CH_STAR) phase_n = PH_BLOCK_STAR;
				end
				PH_BLOCK_STAR: begin
					if (item.data == CH_SLASH) begin
						phase_n = PH_NOISE;
					end else if (item.data != CH_STAR) begin
						phase_n = PH_BLOCK;
					end
				end
				PH_LINE: begin
					if (item.data == CH_LF) phase_n = PH_NOISE;
				end
				PH_WORD: begin
					if (is_letter(item.data)) begin
						mask_n = letter_mask;
						cnt_n  = cnt_inc;
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: phase_n = phase_q;
			endcase
		end
	end

	// lowest matching word wins
	always_comb begin
		code = KW_NONE;
		if (phase_n == PH_WORD || phase_n == PH_DONE) begin
			for (int k = NUM_WORDS - 1; k >= 0; k--) begin
				if (mask_n[k] && cnt_n == WORD_LEN[k]) code = kw_code_t'(3'(k + 1));
			end
		end
	end

	assign result.valid = step && item.last;
	assign result.code  = code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NOISE;
			mask_q  <= '1;
			cnt_q   <= '0;
		end else if (step) begin
			if (item.last) begin
				phase_q <= PH_NOISE;
				mask_q  <= '1;
				cnt_q   <= '0;
			end else begin
				phase_q <= phase_n;
				mask_q  <= mask_n;
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule

// ===== sv/sqlc_out.sv =====
// ----------------------------------------------------------------------------
// sqlc_out
// Result register holding one classification until the sink takes it.
// ----------------------------------------------------------------------------
module sqlc_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sqlc_pkg::sqlc_result_t result,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic                   out_read_only,
	output sqlc_pkg::kw_code_t     out_code,
	output logic                   full_stall
);
	import sqlc_pkg::*;

	logic     valid_q;
	kw_code_t code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= result.valid || (valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			code_q <= result.code;
		end
	end

	assign out_valid     = valid_q;
	assign out_code      = code_q;
	assign out_read_only = (code_q != KW_NONE);
	// a new result may only land when the register is empty or is taken this cycle
	assign full_stall    = valid_q && !out_ready;

endmodule

// ===== sv/sql_read_only_classifier.sv =====
// a final item's result passes from the input register through the result register onto m_axis
// throughput: one byte per cycle, except while a final item waits for room in the result register
// a final item waits in the input register only while the result register is full and not being taken
// reset (arst_n low) clears the scanner to the leading-noise phase and drops all valid flags
// ----------------------------------------------------------------------------
// sql_read_only_classifier
// Classifies a byte stream of SQL text by its leading keyword as read-only or not.
// ----------------------------------------------------------------------------
module sql_read_only_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] statement_byte
	input  logic       s_axis_tuser,  // [0] byte_present
	input  logic       s_axis_tlast,  // end_of_statement
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [0] read_only, [3:1] keyword_code, [7:4] zero
);
	import sqlc_pkg::*;

	sqlc_item_t   item_s1;
	logic         valid_s1;
	logic         advance;
	logic         step;
	logic         full_stall;
	logic         ro;
	kw_code_t     code;
	sqlc_result_t result;

	// only a final item needs room in the result register
	assign advance       = !(item_s1.last && full_stall);
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data    <= s_axis_tdata;
			item_s1.present <= s_axis_tuser;
			item_s1.last    <= s_axis_tlast;
		end
	end

	sqlc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	sqlc_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.result        (result),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_read_only (ro),
		.out_code      (code),
		.full_stall    (full_stall)
	);

	assign m_axis_tdata = {4'b0000, code, ro};

	a_ro_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] != 3'd0)))
		else $error("read_only disagrees with keyword_code");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3:1] <= KW_EXPLAIN))
		else $error("keyword_code out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && valid_s1 && item_s1.last))
		else $error("input stalled without a blocked final item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !full_stall)
		else $error("result written over an untaken result");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of sql_read_only_classifier. Statements are sent byte by
// byte: a short directed set first, then random statements built from noise,
// comments, keywords in mixed case and near misses. A predictor inside the
// scoreboard tracks the scanner and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sqlc_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 475;

	typedef enum logic [2:0] {
		SC_NOISE, SC_SLASH, SC_DASH, SC_BLOCK, SC_BLOCK_STAR, SC_LINE, SC_WORD, SC_DONE
	} scan_t;

	class keyword_board;
		string words [5] = '{"SELECT", "SHOW", "DESCRIBE", "DESC", "EXPLAIN"};
		scan_t phase;
		logic [4:0] alive;
		logic [3:0] nletters;
		kw_code_t expected_codes [$];
		int errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			phase = SC_NOISE;
			alive = 5'h1F;
			nletters = 4'd0;
		endfunction

		function int pending();
			return expected_codes.size();
		endfunction

		function void take_letter(logic [7:0] c);
			logic [7:0] up;
			logic [4:0] keep;
			up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
			keep = '0;
			for (int k = 0; k < 5; k++)
				if (alive[k] && nletters < words[k].len() && words[k][nletters] == up)
					keep[k] = 1'b1;
			alive = keep;
			if (nletters != 4'd15)
				nletters++;
		endfunction

		function void classify_byte(logic [7:0] c);
			bit space;
			bit letter;
			space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
			letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
			case (phase)
				SC_NOISE: begin
					if (!space) begin
						if (c == CH_SLASH)
							phase = SC_SLASH;
						else if (c == CH_DASH)
							phase = SC_DASH;
						else if (c == CH_HASH)
							phase = SC_LINE;
						else if (letter) begin
							phase = SC_WORD;
							take_letter(c);
						end else
							phase = SC_DONE;
					end
				end
				SC_SLASH: phase = (c == CH_STAR) ? SC_BLOCK : SC_DONE;
				SC_DASH: phase = (c == CH_DASH) ? SC_LINE : SC_DONE;
				SC_BLOCK: begin
					if (c == CH_STAR)
						phase = SC_BLOCK_STAR;
				end
				SC_BLOCK_STAR: begin
					if (c == CH_SLASH)
						phase = SC_NOISE;
					else if (c != CH_STAR)
						phase = SC_BLOCK;
				end
				SC_LINE: begin
					if (c == CH_LF)
						phase = SC_NOISE;
				end
				SC_WORD: begin
					if (letter)
						take_letter(c);
					else
						phase = SC_DONE;
				end
				default: ;
			endcase
		endfunction

		function kw_code_t matched_word();
			if (phase != SC_WORD && phase != SC_DONE)
				return KW_NONE;
			for (int k = 0; k < 5; k++)
				if (alive[k] && nletters == words[k].len())
					return kw_code_t'(k + 1);
			return KW_NONE;
		endfunction

		function void note_request(logic [7:0] data, logic present, logic last);
			if (present)
				classify_byte(data);
			if (last) begin
				expected_codes = {expected_codes, matched_word()};
				restart();
			end
		endfunction

		function void check_result(logic [7:0] tdata);
			kw_code_t exp_code;
			if (expected_codes.size() == 0) begin
				$error("result 0x%02h arrived with no statement pending", tdata);
				errors++;
				return;
			end
			exp_code = expected_codes.pop_front();
			if (tdata[0] !== (exp_code != KW_NONE)) begin
				$error("read_only: expected %0d, got %0d", exp_code != KW_NONE, tdata[0]);
				errors++;
			end
			if (tdata[3:1] !== exp_code) begin
				$error("keyword_code: expected %0d, got %0d", exp_code, tdata[3:1]);
				errors++;
			end
			if (tdata[7:4] !== 4'd0) begin
				$error("pad bits: expected 0, got 0x%0h", tdata[7:4]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	keyword_board board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	sql_read_only_classifier u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_item(input logic [7:0] data, input logic present, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= present;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s, input bit bare_end);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, !bare_end && i == s.len() - 1);
		if (bare_end || s.len() == 0)
			send_item(8'hFF, 1'b0, 1'b1);
	endtask

	function automatic logic [7:0] comment_byte();
		case ($urandom_range(3))
			0: return CH_STAR;
			1: return CH_SLASH;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] any_letter();
		return 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
	endfunction

	task automatic add_noise(ref logic [7:0] q [$]);
		logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		case ($urandom_range(3))
			0: q = {q, blanks[$urandom_range(5)]};
			1: begin
				q = {q, CH_SLASH};
				q = {q, CH_STAR};
				repeat ($urandom_range(4)) q = {q, comment_byte()};
				q = {q, CH_STAR};
				q = {q, CH_SLASH};
			end
			2: begin
				q = {q, CH_HASH};
				repeat ($urandom_range(4)) q = {q, comment_byte()};
				q = {q, CH_LF};
			end
			default: begin
				q = {q, CH_DASH};
				q = {q, CH_DASH};
				repeat ($urandom_range(4)) q = {q, comment_byte()};
				q = {q, CH_LF};
			end
		endcase
	endtask

	task automatic random_statement();
		logic [7:0] text [$];
		logic [7:0] tail_start [4] = '{8'h20, 8'h3B, 8'h28, CH_STAR};
		string w;
		int pick;
		int wlen;
		int cut;
		bit bare;
		text = {};
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(6)) text = {text, 8'($urandom)};
		end else begin
			repeat ($urandom_range(3)) add_noise(text);
			pick = $urandom_range(99);
			if (pick < 55) begin
				w = board.words[$urandom_range(4)];
				wlen = w.len();
				// near misses: one letter short, or one to three letters too many
				if (pick >= 45)
					wlen = $urandom_range(1) ? wlen - 1 : wlen;
				for (int i = 0; i < wlen; i++)
					text = {text, ($urandom_range(1) ? (w[i] | 8'h20) : w[i])};
				if (pick >= 45 && wlen == w.len())
					repeat ($urandom_range(3, 1)) text = {text, any_letter()};
			end else if (pick < 70) begin
				repeat ($urandom_range(17, 1)) text = {text, any_letter()};
			end else if (pick < 80) begin
				text = {text, 8'($urandom)};
			end else if (pick < 90) begin
				text = {text, ($urandom_range(1) ? CH_SLASH : CH_DASH)};
			end
			if ($urandom_range(1)) begin
				text = {text, tail_start[$urandom_range(3)]};
				repeat ($urandom_range(3)) text = {text, 8'($urandom)};
			end
			// cut the statement short, often inside a comment
			if (text.size() > 1 && $urandom_range(11) == 0) begin
				cut = $urandom_range(text.size() - 1, 1);
				while (text.size() > cut)
					void'(text.pop_back());
			end
		end
		bare = ($urandom_range(4) == 0);
		foreach (text[i]) begin
			if ($urandom_range(9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(text[i], 1'b1, !bare && i == text.size() - 1);
		end
		if (bare || text.size() == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty statement, odd first bytes, a lone slash and a dash followed by a letter
		send_text("", 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_text("/", 1'b0);
		send_text("-x", 1'b0);
		// slash-star-slash stays in the comment, then ends unterminated
		send_text("/*/", 1'b1);
		send_text("#x", 1'b0);
		// keyword with a missing byte in the middle
		send_item("s", 1'b1, 1'b0);
		send_item("H", 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_text("oW", 1'b0);
		send_text("\t#\nDesc", 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 85;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 85;
				end
				default: begin
					send_idle_pct = 15;
					recv_stall_pct = 15;
				end
			endcase
			while (items_sent < 25 + (ph + 1) * PHASE_ITEMS)
				random_statement();
			// hold the sender until every result is back
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while (board.pending() != 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/sqlc_pkg.sv
sv/sqlc_scan.sv
sv/sqlc_out.sv
sv/sql_read_only_classifier.sv
dv/tb.sv
